@@ rtl/core/lobm_pkg.sv @@
// ----------------------------------------------------------------------------
// Limit order book matcher package
// Shared widths, constants, book entry types and the ordering function.
// ----------------------------------------------------------------------------
package lobm_pkg;

    localparam int PRICE_W        = 30;
    localparam int AMT_W          = 30;
    localparam int TOTAL_W        = 40;
    localparam int BOOK_DEPTH_DEF = 256;
    localparam logic [TOTAL_W-1:0] BACKLOG_MOD = TOTAL_W'(1000000007);
    localparam int MOD_STEPS      = 5;
    localparam int MOD_SPLIT      = 30;
    localparam int FOLD_W         = 27;
    // Weight of bit MOD_SPLIT after reduction modulo the backlog modulus.
    localparam logic [FOLD_W-1:0] MOD_FOLD =
        FOLD_W'((64'd1 << MOD_SPLIT) % 64'd1000000007);

    typedef struct packed {
        logic               valid;
        logic [PRICE_W-1:0] price;
        logic [AMT_W-1:0]   amount;
    } entry_t;

    typedef struct packed {
        logic pop;
        logic push;
    } book_op_t;

    // True when entry a is served strictly before entry b.
    function automatic logic better(input logic is_max,
                                    input logic [PRICE_W-1:0] pa,
                                    input logic [AMT_W-1:0] aa,
                                    input logic [PRICE_W-1:0] pb,
                                    input logic [AMT_W-1:0] ab);
        logic res;
        if (pa != pb) begin
            res = is_max ? (pa > pb) : (pa < pb);
        end else begin
            res = is_max ? (aa > ab) : (aa < ab);
        end
        return res;
    endfunction

endpackage

@@ rtl/core/lobm_cell.sv @@
// ----------------------------------------------------------------------------
// Book cell
// Holds one resting entry of a sorted book and shifts with its neighbors.
// ----------------------------------------------------------------------------
module lobm_cell #(
    parameter bit IS_MAX = 1'b1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  lobm_pkg::book_op_t op,
    input  lobm_pkg::entry_t new_entry,
    input  lobm_pkg::entry_t left_entry,
    input  lobm_pkg::entry_t right_entry,
    input  logic             left_keep,
    output lobm_pkg::entry_t cell_entry,
    output logic             keep
);
    import lobm_pkg::*;

    logic               valid_reg, valid_next;
    logic [PRICE_W-1:0] price_reg, price_next;
    logic [AMT_W-1:0]   amount_reg, amount_next;

    assign cell_entry = '{valid: valid_reg, price: price_reg, amount: amount_reg};
    assign keep = valid_reg &&
                  !better(IS_MAX, new_entry.price, new_entry.amount, price_reg, amount_reg);

    always_comb begin
        valid_next  = valid_reg;
        price_next  = price_reg;
        amount_next = amount_reg;
        if (op.pop) begin
            valid_next  = right_entry.valid;
            price_next  = right_entry.price;
            amount_next = right_entry.amount;
        end else if (op.push && !keep) begin
            if (left_keep) begin
                valid_next  = 1'b1;
                price_next  = new_entry.price;
                amount_next = new_entry.amount;
            end else begin
                valid_next  = left_entry.valid;
                price_next  = left_entry.price;
                amount_next = left_entry.amount;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        price_reg  <= price_next;
        amount_reg <= amount_next;
    end

endmodule

@@ rtl/core/lobm_book.sv @@
// ----------------------------------------------------------------------------
// Sorted book
// A row of cells kept in service order, best entry in the first cell.
// ----------------------------------------------------------------------------
module lobm_book #(
    parameter int DEPTH  = lobm_pkg::BOOK_DEPTH_DEF,
    parameter bit IS_MAX = 1'b1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  lobm_pkg::book_op_t         op,
    input  lobm_pkg::entry_t           new_entry,
    output lobm_pkg::entry_t           head,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    import lobm_pkg::*;

    localparam int CNT_W = $clog2(DEPTH+1);

    entry_t cells [DEPTH];
    logic   keeps [DEPTH];
    logic [CNT_W-1:0] count_reg, count_next;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        entry_t left_e, right_e;
        logic   left_k;
        if (i == 0) begin : g_first
            assign left_e = '0;
            assign left_k = 1'b1;
        end else begin : g_mid
            assign left_e = cells[i-1];
            assign left_k = keeps[i-1];
        end
        if (i == DEPTH-1) begin : g_last
            assign right_e = '0;
        end else begin : g_inner
            assign right_e = cells[i+1];
        end
        lobm_cell #(.IS_MAX(IS_MAX)) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .op         (op),
            .new_entry  (new_entry),
            .left_entry (left_e),
            .right_entry(right_e),
            .left_keep  (left_k),
            .cell_entry (cells[i]),
            .keep       (keeps[i])
        );
    end

    assign head  = cells[0];
    assign count = count_reg;

    always_comb begin
        count_next = count_reg;
        if (op.pop) begin
            count_next = count_reg - CNT_W'(1);
        end else if (op.push) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/core/limit_order_book_matcher_unit.sv @@
// ----------------------------------------------------------------------------
// Limit order book matcher
// Matches orders against sorted buy and sell books and reports the backlog.
// ----------------------------------------------------------------------------
// One order word is taken at a time. The order then passes through ST_MATCH,
// which removes each resting entry that it fully consumes and then either ends
// matching or takes out a partly filled entry, ST_REINS, which re-sorts that
// entry when there is one, ST_REST, which rests its remainder if its book has
// room, ST_MOD, which reduces the backlog modulo 1000000007 by folding and
// subtraction, and ST_DONE, which posts the result word.
// Posting waits while an earlier result word is still held, and the next order
// is not taken until the result is posted. Each book is a row of BOOK_DEPTH
// cells that shift together, so an insert or a removal moves every cell at
// once.
module limit_order_book_matcher_unit #(
    parameter int BOOK_DEPTH = lobm_pkg::BOOK_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_side,
    input  logic [lobm_pkg::PRICE_W-1:0]  s_price,
    input  logic [lobm_pkg::AMT_W-1:0]    s_amount,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lobm_pkg::PRICE_W-1:0]  m_backlog_mod,
    output logic [lobm_pkg::AMT_W-1:0]    m_traded_amount,
    output logic                          m_book_full
);
    import lobm_pkg::*;

    localparam int CNT_W       = $clog2(BOOK_DEPTH+1);
    localparam int FOLD_PROD_W = TOTAL_W - MOD_SPLIT + FOLD_W;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MATCH, ST_REINS, ST_REST, ST_MOD, ST_DONE
    } state_t;

    state_t state_reg, state_next;
    logic               side_reg, side_next;
    logic [PRICE_W-1:0] price_reg, price_next;
    logic [AMT_W-1:0]   remain_reg, remain_next;
    logic [AMT_W-1:0]   traded_reg, traded_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [TOTAL_W-1:0] red_reg, red_next;
    logic [3:0]         step_reg, step_next;
    logic               full_reg, full_next;
    entry_t             reins_reg, reins_next;
    logic               m_valid_reg, m_valid_next;
    logic [PRICE_W-1:0] m_backlog_reg, m_backlog_next;
    logic [AMT_W-1:0]   m_traded_reg, m_traded_next;
    logic               m_full_reg, m_full_next;

    book_op_t buy_op, sell_op;
    entry_t   buy_x, sell_x, buy_head, sell_head, opp_head;
    logic [CNT_W-1:0] buy_count, sell_count, own_count;
    logic [FOLD_PROD_W-1:0] fold_prod;
    logic [TOTAL_W-1:0]     fold_val;
    logic crosses;

    lobm_book #(.DEPTH(BOOK_DEPTH), .IS_MAX(1'b1)) u_buy (
        .aclk(aclk), .aresetn(aresetn), .op(buy_op), .new_entry(buy_x),
        .head(buy_head), .count(buy_count)
    );
    lobm_book #(.DEPTH(BOOK_DEPTH), .IS_MAX(1'b0)) u_sell (
        .aclk(aclk), .aresetn(aresetn), .op(sell_op), .new_entry(sell_x),
        .head(sell_head), .count(sell_count)
    );

    assign opp_head  = side_reg ? buy_head : sell_head;
    assign own_count = side_reg ? sell_count : buy_count;
    assign crosses   = side_reg ? (opp_head.price >= price_reg)
                                : (opp_head.price <= price_reg);
    assign fold_prod = FOLD_PROD_W'(red_reg[TOTAL_W-1:MOD_SPLIT]) * FOLD_PROD_W'(MOD_FOLD);
    assign fold_val  = TOTAL_W'(fold_prod) + TOTAL_W'(red_reg[MOD_SPLIT-1:0]);

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_backlog_mod   = m_backlog_reg;
    assign m_traded_amount = m_traded_reg;
    assign m_book_full     = m_full_reg;

    always_comb begin
        state_next     = state_reg;
        side_next      = side_reg;
        price_next     = price_reg;
        remain_next    = remain_reg;
        traded_next    = traded_reg;
        total_next     = total_reg;
        red_next       = red_reg;
        step_next      = step_reg;
        full_next      = full_reg;
        reins_next     = reins_reg;
        m_valid_next   = m_valid_reg;
        m_backlog_next = m_backlog_reg;
        m_traded_next  = m_traded_reg;
        m_full_next    = m_full_reg;
        buy_op         = '0;
        sell_op        = '0;
        buy_x          = '{valid: 1'b1, price: price_reg, amount: remain_reg};
        sell_x         = '{valid: 1'b1, price: price_reg, amount: remain_reg};

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    side_next   = s_side;
                    price_next  = s_price;
                    remain_next = s_amount;
                    traded_next = '0;
                    full_next   = 1'b0;
                    state_next  = ST_MATCH;
                end
            end
            ST_MATCH: begin
                if (remain_reg == '0 || !opp_head.valid || !crosses) begin
                    state_next = ST_REST;
                end else if (opp_head.amount <= remain_reg) begin
                    remain_next = remain_reg - opp_head.amount;
                    traded_next = traded_reg + opp_head.amount;
                    total_next  = total_reg - TOTAL_W'(opp_head.amount);
                    if (side_reg) begin
                        buy_op.pop = 1'b1;
                    end else begin
                        sell_op.pop = 1'b1;
                    end
                end else begin
                    reins_next  = '{valid: 1'b1, price: opp_head.price,
                                    amount: opp_head.amount - remain_reg};
                    remain_next = '0;
                    traded_next = traded_reg + remain_reg;
                    total_next  = total_reg - TOTAL_W'(remain_reg);
                    if (side_reg) begin
                        buy_op.pop = 1'b1;
                    end else begin
                        sell_op.pop = 1'b1;
                    end
                    state_next = ST_REINS;
                end
            end
            ST_REINS: begin
                buy_x  = reins_reg;
                sell_x = reins_reg;
                if (side_reg) begin
                    buy_op.push = 1'b1;
                end else begin
                    sell_op.push = 1'b1;
                end
                state_next = ST_REST;
            end
            ST_REST: begin
                if (remain_reg != '0) begin
                    if (own_count >= CNT_W'(BOOK_DEPTH)) begin
                        full_next = 1'b1;
                    end else begin
                        total_next = total_reg + TOTAL_W'(remain_reg);
                        if (side_reg) begin
                            sell_op.push = 1'b1;
                        end else begin
                            buy_op.push = 1'b1;
                        end
                    end
                end
                red_next   = total_next;
                step_next  = 4'(MOD_STEPS - 1);
                state_next = ST_MOD;
            end
            ST_MOD: begin
                if (red_reg[TOTAL_W-1:MOD_SPLIT] != '0) begin
                    red_next = fold_val;
                end else if (red_reg >= BACKLOG_MOD) begin
                    red_next = red_reg - BACKLOG_MOD;
                end
                if (step_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    step_next = step_reg - 4'd1;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_backlog_next = red_reg[PRICE_W-1:0];
                    m_traded_next  = traded_reg;
                    m_full_next    = full_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
        side_reg      <= side_next;
        price_reg     <= price_next;
        remain_reg    <= remain_next;
        traded_reg    <= traded_next;
        red_reg       <= red_next;
        step_reg      <= step_next;
        full_reg      <= full_next;
        reins_reg     <= reins_next;
        m_backlog_reg <= m_backlog_next;
        m_traded_reg  <= m_traded_next;
        m_full_reg    <= m_full_next;
    end

`ifndef ASSERT_OFF
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (buy_op.pop |-> buy_head.valid) and (sell_op.pop |-> sell_head.valid))
        else $error("Entry removed from an empty book.");
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (buy_op.push && !buy_op.pop) |-> (buy_count < CNT_W'(BOOK_DEPTH)))
        else $error("Entry pushed into a full buy book.");
    a_one_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("Second order word taken while one is in progress.");
    a_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |-> (red_reg < BACKLOG_MOD))
        else $error("Backlog reduction left a value out of range.");
`endif

endmodule

@@ tb/sv/tb_limit_order_book_matcher_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Limit order book matcher testbench
// Sends order words through the input channel with random gaps, predicts each
// backlog word with a behavioral copy of both books, and checks every field
// of every backlog word that leaves the block, under random receiver stalls.
// ----------------------------------------------------------------------------
module tb_limit_order_book_matcher_unit;
    import lobm_pkg::*;

    localparam int  DEPTH     = BOOK_DEPTH_DEF;
    localparam bit  SIDE_BUY  = 1'b0;
    localparam bit  SIDE_SELL = 1'b1;
    localparam logic [PRICE_W-1:0] PRICE_MAX = {PRICE_W{1'b1}};
    localparam logic [AMT_W-1:0]   AMT_MAX   = {AMT_W{1'b1}};

    typedef struct {
        bit               side;
        bit [PRICE_W-1:0] price;
        bit [AMT_W-1:0]   amount;
        bit               drain;
    } order_t;

    typedef struct {
        bit [PRICE_W-1:0] backlog;
        bit [AMT_W-1:0]   traded;
        bit               full;
    } backlog_word_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_side = 1'b0;
    logic [PRICE_W-1:0] s_price = '0;
    logic [AMT_W-1:0]   s_amount = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [PRICE_W-1:0] m_backlog_mod;
    logic [AMT_W-1:0]   m_traded_amount;
    logic               m_book_full;

    order_t        pending_orders[$];
    backlog_word_t expected_words[$];
    int            mismatches = 0;
    int            words_seen = 0;
    bit            stimulus_done = 1'b0;

    bit [PRICE_W-1:0] bid_price[DEPTH];
    bit [AMT_W-1:0]   bid_amount[DEPTH];
    bit [PRICE_W-1:0] ask_price[DEPTH];
    bit [AMT_W-1:0]   ask_amount[DEPTH];
    int               bid_count = 0;
    int               ask_count = 0;
    bit [TOTAL_W-1:0] resting_sum = '0;

    limit_order_book_matcher_unit DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_side          (s_side),
        .s_price         (s_price),
        .s_amount        (s_amount),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_backlog_mod   (m_backlog_mod),
        .m_traded_amount (m_traded_amount),
        .m_book_full     (m_book_full)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Matches one order against the opposite book, rests the remainder and
    // appends the backlog word that the block must produce.
    task automatic match_order(input order_t o);
        bit [AMT_W-1:0]   remain;
        bit [AMT_W-1:0]   traded;
        bit [AMT_W-1:0]   take;
        bit               full;
        bit               crosses;
        bit               take_max;
        int               best;
        backlog_word_t    w;
        remain = o.amount;
        traded = '0;
        full = 1'b0;
        take_max = (o.side == SIDE_SELL);
        forever begin
            if (remain == 0) break;
            if (take_max ? (bid_count == 0) : (ask_count == 0)) break;
            best = 0;
            if (take_max) begin
                for (int i = 1; i < bid_count; i++) begin
                    if (bid_price[i] != bid_price[best] ? bid_price[i] > bid_price[best]
                                                        : bid_amount[i] > bid_amount[best])
                        best = i;
                end
                crosses = bid_price[best] >= o.price;
            end else begin
                for (int i = 1; i < ask_count; i++) begin
                    if (ask_price[i] != ask_price[best] ? ask_price[i] < ask_price[best]
                                                        : ask_amount[i] < ask_amount[best])
                        best = i;
                end
                crosses = ask_price[best] <= o.price;
            end
            if (!crosses) break;
            if (take_max) begin
                take = bid_amount[best] < remain ? bid_amount[best] : remain;
                bid_amount[best] -= take;
                if (bid_amount[best] == 0) begin
                    bid_count--;
                    bid_price[best] = bid_price[bid_count];
                    bid_amount[best] = bid_amount[bid_count];
                end
            end else begin
                take = ask_amount[best] < remain ? ask_amount[best] : remain;
                ask_amount[best] -= take;
                if (ask_amount[best] == 0) begin
                    ask_count--;
                    ask_price[best] = ask_price[ask_count];
                    ask_amount[best] = ask_amount[ask_count];
                end
            end
            remain -= take;
            traded += take;
            resting_sum -= TOTAL_W'(take);
        end
        if (remain != 0) begin
            if (take_max) begin
                if (ask_count >= DEPTH) full = 1'b1;
                else begin
                    ask_price[ask_count] = o.price;
                    ask_amount[ask_count] = remain;
                    ask_count++;
                end
            end else begin
                if (bid_count >= DEPTH) full = 1'b1;
                else begin
                    bid_price[bid_count] = o.price;
                    bid_amount[bid_count] = remain;
                    bid_count++;
                end
            end
            if (!full) resting_sum += TOTAL_W'(remain);
        end
        w.backlog = PRICE_W'(resting_sum % BACKLOG_MOD);
        w.traded = traded;
        w.full = full;
        expected_words.push_back(w);
    endtask

    function automatic order_t make_order(bit side, bit [PRICE_W-1:0] price,
                                          bit [AMT_W-1:0] amount, bit drain = 1'b0);
        order_t o;
        o.side = side;
        o.price = price;
        o.amount = amount;
        o.drain = drain;
        return o;
    endfunction

    // Orders clustered in overlapping buy and sell price bands so that books cross often,
    // with some full-range prices and amounts mixed in.
    function automatic order_t band_order();
        bit               side;
        bit [PRICE_W-1:0] price;
        bit [AMT_W-1:0]   amount;
        side = $urandom_range(0, 1);
        if ($urandom_range(0, 9) == 0) price = $urandom_range(0, PRICE_MAX);
        else if (side == SIDE_BUY) price = $urandom_range(1000, 1060);
        else price = $urandom_range(1030, 1090);
        case ($urandom_range(0, 9))
            0:       amount = $urandom_range(1, AMT_MAX);
            1:       amount = AMT_MAX;
            default: amount = $urandom_range(1, 500);
        endcase
        return make_order(side, price, amount);
    endfunction

    // Input driver.
    int  send_gap = 0;
    bit  send_burst = 1'b0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else if (!(s_valid && !s_ready)) begin
            if (s_valid && s_ready) begin
                match_order(pending_orders.pop_front());
                if ($urandom_range(0, 40) == 0) send_burst = !send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 10);
            end
            if (send_gap > 0) begin
                s_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_orders.size() != 0 &&
                         (!pending_orders[0].drain || expected_words.size() == 0)) begin
                s_valid <= 1'b1;
                s_side <= pending_orders[0].side;
                s_price <= pending_orders[0].price;
                s_amount <= pending_orders[0].amount;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result monitor and receiver stalls.
    int  recv_hold = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_hold <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word backlog=%0d traded=%0d full=%0d", $time,
                             m_backlog_mod, m_traded_amount, m_book_full);
                    mismatches++;
                end else begin
                    backlog_word_t w;
                    w = expected_words.pop_front();
                    if (m_backlog_mod !== w.backlog) begin
                        $display("%0t: backlog_mod expected %0d actual %0d", $time,
                                 w.backlog, m_backlog_mod);
                        mismatches++;
                    end
                    if (m_traded_amount !== w.traded) begin
                        $display("%0t: traded_amount expected %0d actual %0d", $time,
                                 w.traded, m_traded_amount);
                        mismatches++;
                    end
                    if (m_book_full !== w.full) begin
                        $display("%0t: book_full expected %0d actual %0d", $time,
                                 w.full, m_book_full);
                        mismatches++;
                    end
                end
                words_seen++;
                if (words_seen == 300) recv_hold = 400;
                else if ($urandom_range(0, 3) == 0) recv_hold = 0;
                else recv_hold = $urandom_range(0, 10);
            end
            if (recv_hold > 0) begin
                m_ready <= 1'b0;
                recv_hold <= recv_hold - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        // Extremes, equal prices, partial fills and zero amount orders.
        pending_orders.push_back(make_order(SIDE_BUY, PRICE_MAX, AMT_MAX));
        pending_orders.push_back(make_order(SIDE_SELL, '0, 1));
        pending_orders.push_back(make_order(SIDE_SELL, '0, AMT_MAX));
        pending_orders.push_back(make_order(SIDE_BUY, '0, 5));
        pending_orders.push_back(make_order(SIDE_BUY, PRICE_MAX, 0));
        pending_orders.push_back(make_order(SIDE_BUY, PRICE_MAX, AMT_MAX));
        pending_orders.push_back(make_order(SIDE_BUY, 500, 10));
        pending_orders.push_back(make_order(SIDE_BUY, 500, 30));
        pending_orders.push_back(make_order(SIDE_BUY, 500, 20));
        pending_orders.push_back(make_order(SIDE_SELL, 500, 35));
        pending_orders.push_back(make_order(SIDE_SELL, 400, 40));
        pending_orders.push_back(make_order(SIDE_SELL, 600, 7));
        pending_orders.push_back(make_order(SIDE_SELL, 600, 3));
        pending_orders.push_back(make_order(SIDE_SELL, 600, 9));
        pending_orders.push_back(make_order(SIDE_BUY, 600, 5));
        pending_orders.push_back(make_order(SIDE_BUY, 700, 100));
        pending_orders.push_back(make_order(SIDE_SELL, 1, AMT_MAX, 1'b1));
        pending_orders.push_back(make_order(SIDE_BUY, PRICE_MAX, AMT_MAX));
        pending_orders.push_back(make_order(SIDE_SELL, 0, 0));
        repeat (600) pending_orders.push_back(band_order());
        // Fill the sell book at high prices until it overflows.
        pending_orders.push_back(make_order(SIDE_SELL, PRICE_MAX - 300, 1, 1'b1));
        repeat (280) begin
            pending_orders.push_back(make_order(SIDE_SELL,
                $urandom_range(PRICE_MAX - 255, PRICE_MAX), $urandom_range(1, AMT_MAX)));
        end
        repeat (20) begin
            pending_orders.push_back(make_order(SIDE_BUY, PRICE_MAX,
                $urandom_range(1, AMT_MAX)));
        end
        repeat (620) pending_orders.push_back(band_order());
        wait (pending_orders.size() == 0 && !s_valid);
        stimulus_done = 1'b1;
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        wait (stimulus_done && expected_words.size() == 0);
        repeat (400) @(posedge aclk);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
